/* hdl/rfp_pkg.sv */
// ---------------------------------------------------------------------------
// Range frame parser package
// Shared types and constants for the byte-wise range frame parser.
// ---------------------------------------------------------------------------
package rfp_pkg;

   localparam int FRAME_LEN_DEFAULT = 17;
   localparam int QUEUE_DEPTH       = 4;
   localparam int READING_WIDTH     = 32;

   // Frame offsets that carry the reading, most significant byte first.
   localparam int DATA_FIRST = 3;
   localparam int DATA_LAST  = 6;

   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_D     = 8'h44;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] MINUS_CODE = 8'h2D;

   localparam int DIV_BASE = 1000;

   typedef enum logic [1:0] {
      HDR_HUNT,
      HDR_SEEN_A,
      HDR_SEEN_AT,
      HDR_IN_FRAME
   } rfp_hdr_type;

   typedef struct packed {
      logic                            valid;
      logic signed [READING_WIDTH-1:0] reading;
   } rfp_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } rfp_qstat_type;

endpackage

/* hdl/rfp_front.sv */
// ---------------------------------------------------------------------------
// Range frame parser front end
// Hunts for the frame header, counts frame bytes, captures the reading and
// hands each complete frame's reading to the queue.
// ---------------------------------------------------------------------------
module rfp_front #(
   parameter int FRAME_LEN = rfp_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            rx_byte,
   input  logic                  push,
   output logic                  full,
   input  logic                  queue_full,
   output rfp_pkg::rfp_entry_type push_beat
);
   import rfp_pkg::*;

   localparam int PosWidth = $clog2(FRAME_LEN);
   localparam logic [PosWidth-1:0] PosFirst = PosWidth'(DATA_FIRST);
   localparam logic [PosWidth-1:0] PosData  = PosWidth'(DATA_LAST);
   localparam logic [PosWidth-1:0] PosLast  = PosWidth'(FRAME_LEN - 1);

   rfp_hdr_type                     state_ff, state_in;
   logic        [PosWidth-1:0]      pos_ff, pos_in;
   logic signed [READING_WIDTH-1:0] capture_ff, capture_in;
   logic                            accept;

   // Only the terminator beat can produce a result, so only it waits for room.
   assign full   = queue_full && (state_ff == HDR_IN_FRAME) && (pos_ff == PosLast);
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= HDR_HUNT;
         pos_ff     <= '0;
         capture_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         capture_ff <= capture_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      pos_in            = pos_ff;
      capture_in        = capture_ff;
      push_beat.valid   = 1'b0;
      push_beat.reading = capture_ff;
      if (accept) begin
         case (state_ff)
            HDR_HUNT: begin
               state_in = (rx_byte == CHAR_A) ? HDR_SEEN_A : HDR_HUNT;
            end
            HDR_SEEN_A: begin
               if (rx_byte == CHAR_T) begin
                  state_in = HDR_SEEN_AT;
               end else begin
                  state_in = (rx_byte == CHAR_A) ? HDR_SEEN_A : HDR_HUNT;
               end
            end
            HDR_SEEN_AT: begin
               if (rx_byte == CHAR_D) begin
                  state_in   = HDR_IN_FRAME;
                  pos_in     = PosFirst;
                  capture_in = '0;
               end else begin
                  state_in = (rx_byte == CHAR_A) ? HDR_SEEN_A : HDR_HUNT;
               end
            end
            HDR_IN_FRAME: begin
               if (pos_ff == PosLast) begin
                  pos_in = '0;
                  if (rx_byte == CHAR_HASH) begin
                     state_in        = HDR_HUNT;
                     push_beat.valid = 1'b1;
                  end else begin
                     // A bad terminator may itself open the next header.
                     state_in = (rx_byte == CHAR_A) ? HDR_SEEN_A : HDR_HUNT;
                  end
               end else if (rx_byte == CHAR_HASH) begin
                  state_in = HDR_HUNT;
                  pos_in   = '0;
               end else begin
                  if (pos_ff >= PosFirst && pos_ff <= PosData) begin
                     capture_in = {capture_ff[READING_WIDTH-9:0], rx_byte};
                  end
                  pos_in = pos_ff + 1'b1;
               end
            end
            default: begin
               state_in = HDR_HUNT;
            end
         endcase
      end
   end

   a_header_clears_capture: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff == HDR_SEEN_AT && rx_byte == CHAR_D)
      |=> (capture_ff == '0 && pos_ff == PosFirst && state_ff == HDR_IN_FRAME))
      else $error("header completion did not restart the capture");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_beat.valid |-> !queue_full)
      else $error("front end pushed into a full queue");

endmodule

/* hdl/rfp_queue.sv */
// ---------------------------------------------------------------------------
// Range frame parser reading queue
// Short first-in first-out store of readings between front and back end.
// ---------------------------------------------------------------------------
module rfp_queue (
   input  logic                                     clock,
   input  logic                                     reset,
   input  rfp_pkg::rfp_entry_type                   push_beat,
   input  logic                                     pop_req,
   output logic signed [rfp_pkg::READING_WIDTH-1:0] head_reading,
   output rfp_pkg::rfp_qstat_type                   qstat
);
   import rfp_pkg::*;

   localparam int PtrWidth   = $clog2(QUEUE_DEPTH);
   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(QUEUE_DEPTH);

   logic signed [READING_WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]           count_ff, count_in;
   logic                            do_push, do_pop;

   assign qstat.full   = (count_ff == CountFull);
   assign qstat.empty  = (count_ff == '0);
   assign do_push      = push_beat.valid && !qstat.full;
   assign do_pop       = pop_req && !qstat.empty;
   assign head_reading = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PtrWidth'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PtrWidth'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_beat.reading;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountFull)
      else $error("queue count beyond its depth");

   a_pointers_track_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CountFull) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with the count");

endmodule

/* hdl/rfp_back.sv */
// ---------------------------------------------------------------------------
// Range frame parser back end
// Divides each queued reading's magnitude by 1000 one hex digit a cycle (the
// last once the output is free); the remainder gives three decimal digits.
// ---------------------------------------------------------------------------
module rfp_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic signed [rfp_pkg::READING_WIDTH-1:0] head_reading,
   input  rfp_pkg::rfp_qstat_type                   qstat,
   output logic                                     pop_req,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [rfp_pkg::READING_WIDTH-1:0] rsp_reading,
   output logic [3:0]                               rsp_digit_ones,
   output logic [3:0]                               rsp_digit_tens,
   output logic [3:0]                               rsp_digit_hundreds,
   output logic [7:0]                               rsp_top_code
);
   import rfp_pkg::*;

   localparam int Steps     = READING_WIDTH / 4;
   localparam int StepWidth = $clog2(Steps);
   localparam logic [StepWidth-1:0] StepLast = StepWidth'(Steps - 1);

   // Quotient digit of one long-division step by 1000.
   function automatic logic [3:0] quo_digit(input logic [13:0] v);
      logic [3:0] d;
      d = '0;
      for (int k = 1; k < 16; k++) begin
         if (v >= 14'(k * DIV_BASE)) d = 4'(k);
      end
      return d;
   endfunction

   function automatic logic [3:0] dec_digit(input logic [9:0] v, input logic [9:0] unit);
      logic [3:0] d;
      d = '0;
      for (int k = 1; k < 10; k++) begin
         if ({4'd0, v} >= 14'(k) * {4'd0, unit}) d = 4'(k);
      end
      return d;
   endfunction

   logic                            busy_ff, busy_in;
   logic [StepWidth-1:0]            step_ff, step_in;
   logic [READING_WIDTH-1:0]        mag_ff, mag_in;
   logic [9:0]                      rem_ff, rem_in;
   logic [7:0]                      quo_ff, quo_in;
   logic signed [READING_WIDTH-1:0] value_ff, value_in;

   logic                            out_valid_ff, out_valid_in;
   logic signed [READING_WIDTH-1:0] out_reading_ff, out_reading_in;
   logic [3:0]                      out_ones_ff, out_ones_in;
   logic [3:0]                      out_tens_ff, out_tens_in;
   logic [3:0]                      out_hund_ff, out_hund_in;
   logic [7:0]                      out_top_ff, out_top_in;

   logic [13:0] step_value;
   logic [3:0]  step_digit;
   logic [9:0]  step_rem;
   logic [7:0]  step_quo;
   logic [9:0]  rem_tens;
   logic        out_free;

   assign step_value = {rem_ff, mag_ff[READING_WIDTH-1 -: 4]};
   assign step_digit = quo_digit(step_value);
   assign step_rem   = 10'(step_value - 14'(step_digit) * 14'(DIV_BASE));
   assign step_quo   = {quo_ff[3:0], step_digit};
   assign out_free   = !out_valid_ff || rsp_pop;
   assign pop_req    = !busy_ff && !qstat.empty;

   assign rsp_empty          = !out_valid_ff;
   assign rsp_reading        = out_reading_ff;
   assign rsp_digit_ones     = out_ones_ff;
   assign rsp_digit_tens     = out_tens_ff;
   assign rsp_digit_hundreds = out_hund_ff;
   assign rsp_top_code       = out_top_ff;

   always_comb begin
      busy_in        = busy_ff;
      step_in        = step_ff;
      mag_in         = mag_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      value_in       = value_ff;
      out_valid_in   = out_valid_ff && !rsp_pop;
      out_reading_in = out_reading_ff;
      out_ones_in    = out_ones_ff;
      out_tens_in    = out_tens_ff;
      out_hund_in    = out_hund_ff;
      out_top_in     = out_top_ff;
      rem_tens       = '0;

      if (pop_req) begin
         // The unsigned negation gives the right magnitude for the most
         // negative reading as well.
         busy_in  = 1'b1;
         step_in  = '0;
         value_in = head_reading;
         mag_in   = head_reading[READING_WIDTH-1] ? (~head_reading + 1'b1) : head_reading;
         rem_in   = '0;
         quo_in   = '0;
      end else if (busy_ff) begin
         if (step_ff != StepLast) begin
            step_in = step_ff + 1'b1;
            mag_in  = {mag_ff[READING_WIDTH-5:0], 4'd0};
            rem_in  = step_rem;
            quo_in  = step_quo;
         end else if (out_free) begin
            busy_in        = 1'b0;
            out_valid_in   = 1'b1;
            out_reading_in = value_ff;
            out_hund_in    = dec_digit(step_rem, 10'd100);
            rem_tens       = step_rem - 10'(out_hund_in) * 10'd100;
            out_tens_in    = dec_digit(rem_tens, 10'd10);
            out_ones_in    = 4'(rem_tens - 10'(out_tens_in) * 10'd10);
            out_top_in     = value_ff[READING_WIDTH-1] ? MINUS_CODE : step_quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      value_ff       <= value_in;
      out_reading_ff <= out_reading_in;
      out_ones_ff    <= out_ones_in;
      out_tens_ff    <= out_tens_in;
      out_hund_ff    <= out_hund_in;
      out_top_ff     <= out_top_in;
   end

   a_remainder_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < 10'(DIV_BASE)))
      else $error("division remainder out of range");

   a_result_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ones_ff < 4'd10 && out_tens_ff < 4'd10 && out_hund_ff < 4'd10))
      else $error("result digit is not decimal");

endmodule

/* hdl/range_frame_parser.sv */
// ---------------------------------------------------------------------------
// Range frame parser
// Byte-wise parser for "ATD" framed range readings with display digits.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle; a byte stalls only at a frame terminator
//   while the four-entry reading queue is full.
// Results: the back end takes one queued reading at a time and divides it
//   one hex digit a cycle; the last digit waits for a free result register.
// Reset: synchronous; clears the header hunt, queue and result register.
module range_frame_parser #(
   parameter int FRAME_LEN = rfp_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [7:0]                               req_rx_byte,
   input  logic                                     push,
   output logic                                     full,
   output logic                                     empty,
   input  logic                                     pop,
   output logic signed [rfp_pkg::READING_WIDTH-1:0] rsp_reading,
   output logic [3:0]                               rsp_digit_ones,
   output logic [3:0]                               rsp_digit_tens,
   output logic [3:0]                               rsp_digit_hundreds,
   output logic [7:0]                               rsp_top_code
);
   import rfp_pkg::*;

   rfp_entry_type                   push_beat;
   rfp_qstat_type                   qstat;
   logic                            pop_req;
   logic signed [READING_WIDTH-1:0] head_reading;

   rfp_front #(
      .FRAME_LEN(FRAME_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_rx_byte),
      .push      (push),
      .full      (full),
      .queue_full(qstat.full),
      .push_beat (push_beat)
   );

   rfp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_beat   (push_beat),
      .pop_req     (pop_req),
      .head_reading(head_reading),
      .qstat       (qstat)
   );

   rfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_reading      (head_reading),
      .qstat             (qstat),
      .pop_req           (pop_req),
      .rsp_empty         (empty),
      .rsp_pop           (pop),
      .rsp_reading       (rsp_reading),
      .rsp_digit_ones    (rsp_digit_ones),
      .rsp_digit_tens    (rsp_digit_tens),
      .rsp_digit_hundreds(rsp_digit_hundreds),
      .rsp_top_code      (rsp_top_code)
   );

endmodule

/* tb/tb_range_frame_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Range frame parser testbench
// Feeds the parser whole "ATD" frames, broken frames and line noise one byte
// per beat. A byte-level model of the parser predicts each reported reading
// and its display digits. Results are checked in order, field by field,
// under three mixes of random stalls on either side, the last with none.
// ---------------------------------------------------------------------------
module tb_range_frame_parser;
   import rfp_pkg::*;

   localparam int FRAME_LEN      = FRAME_LEN_DEFAULT;
   localparam int RESULT_LATENCY = 9;

   typedef struct packed {
      logic signed [READING_WIDTH-1:0] reading;
      logic [3:0]                      ones;
      logic [3:0]                      tens;
      logic [3:0]                      hundreds;
      logic [7:0]                      top;
   } display_type;

   typedef enum {ROW_GOOD, ROW_EARLY_HASH, ROW_BAD_TERM} row_kind_type;
   typedef enum {LEAD_NONE, LEAD_DOUBLE_A, LEAD_AT, LEAD_AT_HASH} lead_type;

   typedef struct {
      row_kind_type kind;
      lead_type     lead;
      logic [31:0]  value;
      int           arg;
      bit           typed;
      display_type  exp;
   } row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [7:0]                      req_rx_byte = 8'h00;
   logic                            push = 1'b0;
   logic                            full;
   logic                            empty;
   logic                            pop = 1'b0;
   logic signed [READING_WIDTH-1:0] rsp_reading;
   logic [3:0]                      rsp_digit_ones;
   logic [3:0]                      rsp_digit_tens;
   logic [3:0]                      rsp_digit_hundreds;
   logic [7:0]                      rsp_top_code;

   // Parser model state.
   rfp_hdr_type hdr_state = HDR_HUNT;
   logic [5:0]  frame_ofs = '0;
   logic [31:0] shift_word = '0;
   logic [31:0] held_reading = '0;

   display_type pending_displays[$];
   bit          typed_armed = 1'b0;
   display_type typed_display;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int frames_broken = 0;
   int readings_checked = 0;
   int error_count = 0;

   // Directed frames; the typed rows are the ones whose digits are obvious.
   row_type dir_rows [14] = '{
      '{ROW_GOOD, LEAD_NONE, 32'h0000_0000, 0, 1'b1, '{32'sd0, 4'd0, 4'd0, 4'd0, 8'd0}},
      '{ROW_GOOD, LEAD_NONE, 32'h7FFF_FFFF, 0, 1'b1,
        '{32'sh7FFF_FFFF, 4'd7, 4'd4, 4'd6, 8'd155}},
      '{ROW_GOOD, LEAD_NONE, 32'h8000_0000, 0, 1'b1,
        '{32'sh8000_0000, 4'd8, 4'd4, 4'd6, MINUS_CODE}},
      '{ROW_GOOD, LEAD_NONE, 32'hFFFF_FFFF, 0, 1'b1, '{-32'sd1, 4'd1, 4'd0, 4'd0, MINUS_CODE}},
      '{ROW_GOOD, LEAD_DOUBLE_A, 32'd999, 0, 1'b1, '{32'sd999, 4'd9, 4'd9, 4'd9, 8'd0}},
      '{ROW_GOOD, LEAD_AT, 32'd255999, 0, 1'b1, '{32'sd255999, 4'd9, 4'd9, 4'd9, 8'd255}},
      '{ROW_GOOD, LEAD_AT_HASH, 32'd256000, 0, 1'b1, '{32'sd256000, 4'd0, 4'd0, 4'd0, 8'd0}},
      '{ROW_EARLY_HASH, LEAD_NONE, 32'd1234, DATA_FIRST, 1'b0, '0},
      '{ROW_EARLY_HASH, LEAD_NONE, 32'd5678, FRAME_LEN - 2, 1'b0, '0},
      '{ROW_BAD_TERM, LEAD_NONE, 32'd42, CHAR_A, 1'b0, '0},
      '{ROW_GOOD, LEAD_NONE, 32'hFFFF_FC18, 0, 1'b0, '0},
      '{ROW_BAD_TERM, LEAD_NONE, 32'd77, 8'hFF, 1'b0, '0},
      '{ROW_GOOD, LEAD_NONE, 32'd123456789, 0, 1'b0, '0},
      '{ROW_GOOD, LEAD_DOUBLE_A, 32'h0102_0304, 0, 1'b0, '0}
   };

   range_frame_parser #(
      .FRAME_LEN(FRAME_LEN)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .push               (push),
      .full               (full),
      .empty              (empty),
      .pop                (pop),
      .rsp_reading        (rsp_reading),
      .rsp_digit_ones     (rsp_digit_ones),
      .rsp_digit_tens     (rsp_digit_tens),
      .rsp_digit_hundreds (rsp_digit_hundreds),
      .rsp_top_code       (rsp_top_code)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   // Header hunt: a byte that breaks the match is tried again as a leading 'A'.
   function automatic void advance_header(input logic [7:0] b);
      if (hdr_state == HDR_SEEN_A && b == CHAR_T) begin
         hdr_state = HDR_SEEN_AT;
      end else if (hdr_state == HDR_SEEN_AT && b == CHAR_D) begin
         hdr_state  = HDR_IN_FRAME;
         frame_ofs  = 6'(DATA_FIRST);
         shift_word = '0;
      end else begin
         hdr_state = (b == CHAR_A) ? HDR_SEEN_A : HDR_HUNT;
      end
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output display_type d);
      logic        neg;
      logic [31:0] mag;
      d = '0;
      if (hdr_state != HDR_IN_FRAME) begin
         advance_header(b);
         return 1'b0;
      end
      if (frame_ofs >= FRAME_LEN - 1) begin
         hdr_state = HDR_HUNT;
         frame_ofs = '0;
         if (b != CHAR_HASH) begin
            advance_header(b);
            return 1'b0;
         end
         held_reading = shift_word;
         neg          = held_reading[31];
         mag          = neg ? (32'd0 - held_reading) : held_reading;
         d.reading    = held_reading;
         d.ones       = 4'(mag % 10);
         d.tens       = 4'((mag / 10) % 10);
         d.hundreds   = 4'((mag / 100) % 10);
         d.top        = neg ? MINUS_CODE : 8'(mag / DIV_BASE);
         return 1'b1;
      end
      if (b == CHAR_HASH) begin
         hdr_state = HDR_HUNT;
         frame_ofs = '0;
         return 1'b0;
      end
      if (frame_ofs >= DATA_FIRST && frame_ofs <= DATA_LAST)
         shift_word = {shift_word[23:0], b};
      frame_ofs = frame_ofs + 6'd1;
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      display_type d;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      req_rx_byte <= b;
      push        <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      bytes_sent++;
      if (parse_byte(b, d)) begin
         if (typed_armed) begin
            d           = typed_display;
            typed_armed = 1'b0;
         end
         pending_displays.push_back(d);
      end
   endtask

   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_HASH);
      return b;
   endfunction

   task automatic send_lead(input lead_type lead);
      case (lead)
         LEAD_DOUBLE_A: begin
            send_byte(CHAR_A);
         end
         LEAD_AT: begin
            send_byte(CHAR_A);
            send_byte(CHAR_T);
         end
         LEAD_AT_HASH: begin
            send_byte(CHAR_A);
            send_byte(CHAR_T);
            send_byte(CHAR_HASH);
         end
         default: ;
      endcase
   endtask

   // One frame by offset; a defect either cuts it short with '#' or
   // replaces the terminator.
   task automatic send_frame(input row_kind_type kind, input logic [31:0] value, input int arg);
      logic [7:0] b;
      frames_sent++;
      if (kind != ROW_GOOD) frames_broken++;
      for (int ofs = 0; ofs < FRAME_LEN; ofs++) begin
         if (kind == ROW_EARLY_HASH && ofs == arg) begin
            send_byte(CHAR_HASH);
            break;
         end
         case (ofs)
            0:       b = CHAR_A;
            1:       b = CHAR_T;
            2:       b = CHAR_D;
            3:       b = value[31:24];
            4:       b = value[23:16];
            5:       b = value[15:8];
            6:       b = value[7:0];
            default: b = (ofs == FRAME_LEN - 1)
                         ? ((kind == ROW_BAD_TERM) ? 8'(arg) : CHAR_HASH)
                         : filler_byte();
         endcase
         send_byte(b);
      end
   endtask

   task automatic run_random(input int byte_goal);
      logic [31:0] value;
      int          pick;
      int          n;
      while (bytes_sent < byte_goal) begin
         // Line noise between frames, weighted towards header and marker bytes.
         if ($urandom_range(0, 99) < 30) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               case ($urandom_range(0, 4))
                  0:       send_byte(CHAR_A);
                  1:       send_byte(CHAR_T);
                  2:       send_byte(CHAR_D);
                  3:       send_byte(CHAR_HASH);
                  default: send_byte(8'($urandom_range(0, 255)));
               endcase
            end
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            value = $urandom;
         end else if (pick < 80) begin
            value = 32'($urandom_range(0, 600000)) - 32'd300000;
         end else if (pick < 90) begin
            value = {$urandom_range(0, 1) ? 8'h7F : 8'h80, 24'($urandom)};
         end else begin
            case ($urandom_range(0, 8))
               0:       value = 32'h0000_0000;
               1:       value = 32'hFFFF_FFFF;
               2:       value = 32'h7FFF_FFFF;
               3:       value = 32'h8000_0000;
               4:       value = 32'd999;
               5:       value = 32'd1000;
               6:       value = -32'd999;
               7:       value = 32'd255999;
               default: value = 32'd256000;
            endcase
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_frame(ROW_GOOD, value, 0);
         end else if (pick < 80) begin
            send_frame(ROW_EARLY_HASH, value, $urandom_range(DATA_FIRST, FRAME_LEN - 2));
         end else if (pick < 90) begin
            send_frame(ROW_BAD_TERM, value, filler_byte());
         end else begin
            // A header that breaks off part way.
            send_byte(CHAR_A);
            if ($urandom_range(0, 1)) send_byte(CHAR_T);
            send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_displays.size() != 0) @(posedge clock);
   endtask

   // Result side: check each beat against the oldest pending reading.
   always @(posedge clock) begin
      display_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (pending_displays.size() == 0) begin
               $error("rsp beat with no reading pending: rsp_reading %0d", rsp_reading);
               error_count++;
            end else begin
               want = pending_displays.pop_front();
               readings_checked++;
               if (rsp_reading !== want.reading) begin
                  $error("rsp_reading: expected %0d, got %0d", want.reading, rsp_reading);
                  error_count++;
               end
               if (rsp_digit_ones !== want.ones) begin
                  $error("rsp_digit_ones: expected %0d, got %0d", want.ones, rsp_digit_ones);
                  error_count++;
               end
               if (rsp_digit_tens !== want.tens) begin
                  $error("rsp_digit_tens: expected %0d, got %0d", want.tens, rsp_digit_tens);
                  error_count++;
               end
               if (rsp_digit_hundreds !== want.hundreds) begin
                  $error("rsp_digit_hundreds: expected %0d, got %0d",
                         want.hundreds, rsp_digit_hundreds);
                  error_count++;
               end
               if (rsp_top_code !== want.top) begin
                  $error("rsp_top_code: expected %0d, got %0d", want.top, rsp_top_code);
                  error_count++;
               end
            end
         end
         pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 28;
      recv_idle_pct = 59;
      foreach (dir_rows[i]) begin
         send_lead(dir_rows[i].lead);
         typed_armed   = dir_rows[i].typed;
         typed_display = dir_rows[i].exp;
         send_frame(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].arg);
         typed_armed = 1'b0;
      end
      run_random(bytes_sent + 460);

      // Hold the sender off until every pending reading has been taken.
      wait_drained();

      send_idle_pct = 59;
      recv_idle_pct = 28;
      run_random(bytes_sent + 460);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(bytes_sent + 460);

      wait_drained();
      repeat (RESULT_LATENCY + 20) @(posedge clock);

      $display("Run covered %0d bytes in %0d frames, %0d of them deliberately broken,",
               bytes_sent, frames_sent, frames_broken);
      $display("with %0d readings checked across three stall mixes.", readings_checked);
      if (error_count == 0 && pending_displays.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
